>>> hdl/aas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Aligned access splitter package
// Shared constants, codes and control structures.
// ----------------------------------------------------------------------------
package aas_pkg;

	localparam int unsigned MAX_BYTES = 16384;
	localparam int unsigned MAX_OUT   = 20;
	localparam int unsigned CHUNK_MIN = 1024;
	localparam int unsigned CHUNK_MAX = 16384;

	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned COUNT_W  = 15;
	localparam int unsigned ELEM_W   = 13;
	localparam int unsigned OFFS_W   = 14;
	localparam int unsigned WCODE_W  = 2;
	localparam int unsigned CFG_W    = 15;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned BURST_CNT_W = $clog2(MAX_OUT);

	localparam logic [WCODE_W-1:0] WIDTH_BYTE = 2'd0;
	localparam logic [WCODE_W-1:0] WIDTH_HALF = 2'd1;
	localparam logic [WCODE_W-1:0] WIDTH_WORD = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CHUNK = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_CHUNK  = 1'b1;

	localparam logic [CFG_W-1:0] WRITE_CHUNK_RESET = 15'd1024;
	localparam logic [CFG_W-1:0] READ_CHUNK_RESET  = 15'd2048;

	typedef struct packed {
		logic load;     // capture a new transaction
		logic advance;  // emit one burst into the output register
	} ctl_cmd_t;

	typedef struct packed {
		logic req_empty;  // incoming transaction carries no bytes
		logic burst_last; // burst being built closes the transaction
	} dp_status_t;

	// Clear the low two bits and clamp to the legal chunk range.
	function automatic logic [COUNT_W-1:0] chunk_limit(input logic [CFG_W-1:0] r);
		logic [COUNT_W-1:0] c;
		c = r & 15'h7FFC;
		if (c < COUNT_W'(CHUNK_MIN)) begin
			c = COUNT_W'(CHUNK_MIN);
		end else if (c > COUNT_W'(CHUNK_MAX)) begin
			c = COUNT_W'(CHUNK_MAX);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

>>> hdl/aas_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Access request channel
// Valid/ready channel carrying one memory access request.
// ----------------------------------------------------------------------------
interface aas_req_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [aas_pkg::ADDR_W-1:0]    start_addr;
	logic [aas_pkg::COUNT_W-1:0]   byte_count;

	modport source (output valid, operation, start_addr, byte_count, input ready);
	modport sink   (input valid, operation, start_addr, byte_count, output ready);
endinterface
`default_nettype wire

>>> hdl/aas_burst_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Burst descriptor channel
// Valid/ready channel carrying one aligned bus burst.
// ----------------------------------------------------------------------------
interface aas_burst_if;
	logic                          valid;
	logic                          ready;
	logic                          is_write;
	logic [aas_pkg::WCODE_W-1:0]   width_code;
	logic [aas_pkg::ADDR_W-1:0]    burst_addr;
	logic [aas_pkg::ELEM_W-1:0]    element_count;
	logic [aas_pkg::OFFS_W-1:0]    buffer_offset;
	logic                          last;

	modport source (output valid, is_write, width_code, burst_addr, element_count,
		buffer_offset, last, input ready);
	modport sink   (input valid, is_write, width_code, burst_addr, element_count,
		buffer_offset, last, output ready);
endinterface
`default_nettype wire

>>> hdl/aligned_access_splitter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Aligned access splitter
// Splits one memory access request into naturally aligned bus bursts.
// ----------------------------------------------------------------------------
// A request (direction, start address, byte count) is taken on the req channel
// and comes out on the burst channel as a run of aligned bursts: a head byte if
// the address is odd, a head halfword if it sits at 2 mod 4, word bursts no
// longer than the direction's chunk limit, then a tail halfword and tail byte.
// The final burst of a request carries last. A zero byte count is accepted and
// produces nothing. One request is in work at a time: the unit emits one burst
// per cycle into its output register, set by the single burst-building step of
// the datapath, while the burst channel keeps up; the unit waits whenever the
// burst channel holds off. The next request is taken as soon as the last
// burst has been built, even while that burst still waits to be taken. Counts
// above 16384 saturate; the chunk registers are written through
// cfg_we/cfg_index/cfg_data (index 0 write chunk, index 1 read chunk); the user
// must write them only while the unit is idle; the unit does not enforce this.
// ----------------------------------------------------------------------------
module aligned_access_splitter_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [aas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [aas_pkg::CFG_W-1:0]      cfg_data,
	aas_req_if.sink                             req,
	aas_burst_if.source                         burst
);

	aas_pkg::ctl_cmd_t   cmd;
	aas_pkg::dp_status_t status;

	// Controller: accept a transaction, then advance one burst per free slot.
	aas_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.out_valid (burst.valid),
		.out_ready (burst.ready),
		.cmd       (cmd),
		.status    (status)
	);

	// Datapath: hold chunk limits, walk the address and build each burst.
	aas_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_operation      (req.operation),
		.in_start_addr     (req.start_addr),
		.in_byte_count     (req.byte_count),
		.cmd               (cmd),
		.status            (status),
		.out_is_write      (burst.is_write),
		.out_width_code    (burst.width_code),
		.out_burst_addr    (burst.burst_addr),
		.out_element_count (burst.element_count),
		.out_buffer_offset (burst.buffer_offset),
		.out_last          (burst.last)
	);

`ifndef SYNTHESIS
	// Halfword bursts start on an even address.
	a_half_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		burst.valid && burst.width_code == aas_pkg::WIDTH_HALF
		|-> burst.burst_addr[0] == 1'b0)
		else $error("misaligned halfword burst");

	// A waiting non-final burst means the transaction is still in work.
	a_mid_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		burst.valid && !burst.last |-> !req.ready)
		else $error("input open in the middle of a transaction");

	// Byte and halfword bursts move exactly one element.
	a_narrow_single: assert property (@(posedge clk) disable iff (!arst_n)
		burst.valid && burst.width_code != aas_pkg::WIDTH_WORD
		|-> burst.element_count == aas_pkg::ELEM_W'(1))
		else $error("narrow burst with more than one element");

	// Word bursts start on a word boundary.
	a_word_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		burst.valid && burst.width_code == aas_pkg::WIDTH_WORD
		|-> burst.burst_addr[1:0] == 2'b00)
		else $error("misaligned word burst");
`endif

endmodule
`default_nettype wire

>>> hdl/aas_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Aligned access splitter controller
// Sequences one transaction at a time and owns the output valid flag.
// ----------------------------------------------------------------------------
module aas_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output aas_pkg::ctl_cmd_t      cmd,
	input  wire aas_pkg::dp_status_t status
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free   = !out_valid_q || out_ready;
	assign req_ready   = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.load    = req_valid && req_ready;
	assign cmd.advance = (state_q == ST_RUN) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// output register: fill on advance, drop when taken
			if (cmd.advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load && !status.req_empty) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.advance && status.burst_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

>>> hdl/aas_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Aligned access splitter datapath
// Chunk registers, walking address/remainder state and the burst register.
// ----------------------------------------------------------------------------
module aas_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [aas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [aas_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                           in_operation,
	input  wire logic [aas_pkg::ADDR_W-1:0]     in_start_addr,
	input  wire logic [aas_pkg::COUNT_W-1:0]    in_byte_count,
	input  wire aas_pkg::ctl_cmd_t              cmd,
	output aas_pkg::dp_status_t                 status,
	output logic                                out_is_write,
	output logic [aas_pkg::WCODE_W-1:0]         out_width_code,
	output logic [aas_pkg::ADDR_W-1:0]          out_burst_addr,
	output logic [aas_pkg::ELEM_W-1:0]          out_element_count,
	output logic [aas_pkg::OFFS_W-1:0]          out_buffer_offset,
	output logic                                out_last
);

	localparam int unsigned CW = aas_pkg::COUNT_W;

	logic [aas_pkg::CFG_W-1:0]       wr_chunk_q;
	logic [aas_pkg::CFG_W-1:0]       rd_chunk_q;

	logic                            wr_q;
	logic [aas_pkg::ADDR_W-1:0]      addr_q;
	logic [CW-1:0]                   rem_q;
	logic [aas_pkg::OFFS_W-1:0]      offs_q;
	logic [CW-1:0]                   chunk_q;
	logic [aas_pkg::BURST_CNT_W-1:0] cnt_q;

	logic [CW-1:0]                   sat_count;
	logic [CW-1:0]                   body;
	logic [CW-1:0]                   piece;
	logic [CW-1:0]                   step;
	logic [aas_pkg::WCODE_W-1:0]     wcode;
	logic [aas_pkg::ELEM_W-1:0]      elems;

	assign sat_count = (in_byte_count > CW'(aas_pkg::MAX_BYTES)) ?
		CW'(aas_pkg::MAX_BYTES) : in_byte_count;

	assign body  = rem_q & ~CW'(3);
	assign piece = (body > chunk_q) ? chunk_q : body;

	// Pick the next aligned burst from the current address and remainder.
	always_comb begin
		wcode = aas_pkg::WIDTH_BYTE;
		step  = CW'(1);
		elems = aas_pkg::ELEM_W'(1);
		priority if (addr_q[0]) begin
			wcode = aas_pkg::WIDTH_BYTE;
		end else if (addr_q[1] && rem_q >= CW'(2)) begin
			wcode = aas_pkg::WIDTH_HALF;
			step  = CW'(2);
		end else if (rem_q >= CW'(4)) begin
			wcode = aas_pkg::WIDTH_WORD;
			step  = piece;
			elems = piece[CW-1:2];
		end else if (rem_q >= CW'(2)) begin
			wcode = aas_pkg::WIDTH_HALF;
			step  = CW'(2);
		end else begin
			wcode = aas_pkg::WIDTH_BYTE;
		end
	end

	assign status.req_empty  = (in_byte_count == '0);
	assign status.burst_last = (rem_q == step) ||
		(cnt_q == aas_pkg::BURST_CNT_W'(aas_pkg::MAX_OUT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_chunk_q <= aas_pkg::WRITE_CHUNK_RESET;
			rd_chunk_q <= aas_pkg::READ_CHUNK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aas_pkg::CFG_WRITE_CHUNK: wr_chunk_q <= cfg_data;
				aas_pkg::CFG_READ_CHUNK:  rd_chunk_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wr_q    <= in_operation;
			addr_q  <= in_start_addr;
			rem_q   <= sat_count;
			offs_q  <= '0;
			cnt_q   <= '0;
			chunk_q <= aas_pkg::chunk_limit(in_operation ? wr_chunk_q : rd_chunk_q);
		end else if (cmd.advance) begin
			addr_q <= addr_q + aas_pkg::ADDR_W'(step);
			rem_q  <= rem_q - step;
			offs_q <= offs_q + step[aas_pkg::OFFS_W-1:0];
			cnt_q  <= cnt_q + aas_pkg::BURST_CNT_W'(1);
		end
		if (cmd.advance) begin
			out_is_write      <= wr_q;
			out_width_code    <= wcode;
			out_burst_addr    <= addr_q;
			out_element_count <= elems;
			out_buffer_offset <= offs_q;
			out_last          <= status.burst_last;
		end
	end

endmodule
`default_nettype wire
